@@ hw/rtl/vpq_pkg.sv @@
package vpq_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 32;
    localparam int ID_WIDTH_DEF   = 16;
    localparam int VOTE_WIDTH_DEF = 16;

    // fixed field widths
    localparam int CMD_W        = 3;
    localparam int LIMIT_W      = 6;
    localparam int STATUS_W     = 2;
    // most results one top-k listing may return
    localparam int RESULT_LIMIT = 32;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_EXTRACT = 3'd2,
        CMD_GET     = 3'd3,
        CMD_TOPK    = 3'd4,
        CMD_CLEAR   = 3'd5
    } t_cmd;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BUMPED  = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_APPLY,
        S_LIST
    } t_state;

    // operation applied to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PLACE,
        CELL_SHIFT,
        CELL_CLEAR
    } t_cell_op;

    // per-cell control from the row
    typedef struct packed {
        t_cell_op op;
        logic     at_or_before;
        logic     at_hole;
    } t_cell_ctl;

endpackage

@@ hw/rtl/vpq_cell.sv @@
module vpq_cell
    import vpq_pkg::*;
#(
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int VOTE_WIDTH = VOTE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [ID_WIDTH-1:0]   i_key_id,
    input  logic [VOTE_WIDTH-1:0] i_new_votes,
    input  logic                  i_prev_valid,
    input  logic [ID_WIDTH-1:0]   i_prev_id,
    input  logic [VOTE_WIDTH-1:0] i_prev_votes,
    input  logic                  i_prev_ahead,
    input  logic                  i_next_valid,
    input  logic [ID_WIDTH-1:0]   i_next_id,
    input  logic [VOTE_WIDTH-1:0] i_next_votes,
    output logic                  o_valid,
    output logic [ID_WIDTH-1:0]   o_id,
    output logic [VOTE_WIDTH-1:0] o_votes,
    output logic                  o_ahead,
    output logic                  o_match
);

    logic                  r_valid;
    logic [ID_WIDTH-1:0]   r_id;
    logic [VOTE_WIDTH-1:0] r_votes;
    logic                  n_valid;
    logic [ID_WIDTH-1:0]   n_id;
    logic [VOTE_WIDTH-1:0] n_votes;

    // key compare against the held entry
    assign o_match = r_valid && (r_id == i_key_id);

    // the new entry sorts before this one: more votes, or equal votes and lower id
    assign o_ahead = r_valid && !o_match &&
                     ((i_new_votes > r_votes) || ((i_new_votes == r_votes) && (i_key_id < r_id)));

    // next content
    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_votes = r_votes;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_PLACE: begin
                if (i_ctl.at_or_before) begin
                    if (i_prev_ahead) begin
                        n_valid = i_prev_valid;
                        n_id    = i_prev_id;
                        n_votes = i_prev_votes;
                    end else if (o_ahead || i_ctl.at_hole) begin
                        n_valid = 1'b1;
                        n_id    = i_key_id;
                        n_votes = i_new_votes;
                    end
                end
            end
            CELL_SHIFT: begin
                n_valid = i_next_valid;
                n_id    = i_next_id;
                n_votes = i_next_votes;
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_votes <= n_votes;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_votes = r_votes;

endmodule

@@ hw/rtl/vpq_chain.sv @@
module vpq_chain
    import vpq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int VOTE_WIDTH = VOTE_WIDTH_DEF,
    localparam int CW        = $clog2(CAPACITY + 1),
    localparam int PW        = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_op              i_op,
    input  logic                  i_wrap,
    input  logic [CW-1:0]         i_hole,
    input  logic [ID_WIDTH-1:0]   i_key_id,
    input  logic [VOTE_WIDTH-1:0] i_new_votes,
    output logic                  o_found,
    output logic [PW-1:0]         o_pos,
    output logic [VOTE_WIDTH-1:0] o_match_votes,
    output logic [ID_WIDTH-1:0]   o_head_id,
    output logic [VOTE_WIDTH-1:0] o_head_votes
);

    logic [CAPACITY-1:0]   c_valid;
    logic [ID_WIDTH-1:0]   c_id    [CAPACITY];
    logic [VOTE_WIDTH-1:0] c_votes [CAPACITY];
    logic [CAPACITY-1:0]   c_ahead;
    logic [CAPACITY-1:0]   c_match;
    t_cell_ctl             c_ctl   [CAPACITY];

    // row of cells, highest entry in cell 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  prev_valid;
        logic [ID_WIDTH-1:0]   prev_id;
        logic [VOTE_WIDTH-1:0] prev_votes;
        logic                  prev_ahead;
        logic                  next_valid;
        logic [ID_WIDTH-1:0]   next_id;
        logic [VOTE_WIDTH-1:0] next_votes;

        // hole position decode
        assign c_ctl[i].op           = i_op;
        assign c_ctl[i].at_or_before = (CW'(i) <= i_hole);
        assign c_ctl[i].at_hole      = (CW'(i) == i_hole);

        if (i == 0) begin : g_first
            assign prev_valid = 1'b0;
            assign prev_id    = '0;
            assign prev_votes = '0;
            assign prev_ahead = 1'b0;
        end else begin : g_inner
            assign prev_valid = c_valid[i-1];
            assign prev_id    = c_id[i-1];
            assign prev_votes = c_votes[i-1];
            assign prev_ahead = c_ahead[i-1];
        end

        // last cell refills from cell 0 when rotating, else with an empty slot
        if (i == CAPACITY - 1) begin : g_last
            assign next_valid = i_wrap && c_valid[0];
            assign next_id    = c_id[0];
            assign next_votes = c_votes[0];
        end else begin : g_body
            assign next_valid = c_valid[i+1];
            assign next_id    = c_id[i+1];
            assign next_votes = c_votes[i+1];
        end

        vpq_cell #(
            .ID_WIDTH   (ID_WIDTH),
            .VOTE_WIDTH (VOTE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (c_ctl[i]),
            .i_key_id     (i_key_id),
            .i_new_votes  (i_new_votes),
            .i_prev_valid (prev_valid),
            .i_prev_id    (prev_id),
            .i_prev_votes (prev_votes),
            .i_prev_ahead (prev_ahead),
            .i_next_valid (next_valid),
            .i_next_id    (next_id),
            .i_next_votes (next_votes),
            .o_valid      (c_valid[i]),
            .o_id         (c_id[i]),
            .o_votes      (c_votes[i]),
            .o_ahead      (c_ahead[i]),
            .o_match      (c_match[i])
        );
    end

    // ids are unique, so at most one cell matches: merge by or
    always_comb begin
        o_pos         = '0;
        o_match_votes = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (c_match[i]) begin
                o_pos         = o_pos | PW'(i);
                o_match_votes = o_match_votes | c_votes[i];
            end
        end
    end

    assign o_found      = |c_match;
    assign o_head_id    = c_id[0];
    assign o_head_votes = c_votes[0];

endmodule

@@ hw/rtl/vote_priority_queue_unit.sv @@
// channel | dir | tdata (low bit up)                                | tuser  | tlast
// s       | in  | command, item_id, initial_votes, top_limit, zeros | -      | -
// m       | out | result_id, result_votes, zeros                    | status | last
//
// other commands and top k on an empty queue: accept, key compare in every cell, then cell
// update with the result load; the next item is accepted only after the update.
// top k on a non-empty queue: the ring of cells rotates once, one step a cycle unless an
// emitting step waits for the result register, and the first n steps each put one result out.
// reset clears cell occupancy, entry count and controller; ids and votes are not cleared.
// a full result register holds the update and each emitting rotation step until the item is taken.
module vote_priority_queue_unit
    import vpq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int VOTE_WIDTH = VOTE_WIDTH_DEF,
    localparam int IN_W      = ((CMD_W + ID_WIDTH + VOTE_WIDTH + LIMIT_W + 7) / 8) * 8,
    localparam int OUT_W     = ((ID_WIDTH + VOTE_WIDTH + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // command, item_id, initial_votes, top_limit, zero fill
    input  logic [IN_W-1:0]     i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // result_id, result_votes, zero fill
    output logic [OUT_W-1:0]    o_m_tdata,
    // status
    output logic [STATUS_W-1:0] o_m_tuser,
    output logic                o_m_tlast
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int PADW = OUT_W - ID_WIDTH - VOTE_WIDTH;

    localparam logic [VOTE_WIDTH-1:0] VOTE_MAX = '1;

    t_state                r_state;
    t_state                n_state;

    // accepted item
    t_cmd                  r_cmd;
    logic [ID_WIDTH-1:0]   r_id;
    logic [VOTE_WIDTH-1:0] r_iv;
    logic [LIMIT_W-1:0]    r_lim;

    // lookup results
    logic                  r_found;
    logic [CW-1:0]         r_hole;
    logic [VOTE_WIDTH-1:0] r_old_votes;
    logic [VOTE_WIDTH-1:0] r_new_votes;
    logic [CW-1:0]         r_total;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_rot;
    logic [CW-1:0]         n_rot;

    // result register
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [ID_WIDTH-1:0]   r_out_id;
    logic [VOTE_WIDTH-1:0] r_out_votes;
    logic                  r_out_last;

    logic                  accept;
    logic                  out_free;
    logic                  load;
    t_status               ld_status;
    logic [ID_WIDTH-1:0]   ld_id;
    logic [VOTE_WIDTH-1:0] ld_votes;
    logic                  ld_last;
    t_cell_op              cell_op;
    logic                  wrap;
    logic                  emitting;
    logic                  list_step;
    logic [CW-1:0]         rot_inc;

    logic                  ch_found;
    logic [PW-1:0]         ch_pos;
    logic [VOTE_WIDTH-1:0] ch_match_votes;
    logic [ID_WIDTH-1:0]   ch_head_id;
    logic [VOTE_WIDTH-1:0] ch_head_votes;

    logic [CMPW-1:0]       lim_ext;
    logic [CMPW-1:0]       cnt_ext;
    logic [CMPW-1:0]       pick;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_m_tready;
    assign emitting   = (r_rot < r_total);
    assign list_step  = !emitting || out_free;
    assign rot_inc    = r_rot + CW'(1);

    vpq_chain #(
        .CAPACITY   (CAPACITY),
        .ID_WIDTH   (ID_WIDTH),
        .VOTE_WIDTH (VOTE_WIDTH)
    ) u_chain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (cell_op),
        .i_wrap        (wrap),
        .i_hole        (r_hole),
        .i_key_id      (r_id),
        .i_new_votes   (r_new_votes),
        .o_found       (ch_found),
        .o_pos         (ch_pos),
        .o_match_votes (ch_match_votes),
        .o_head_id     (ch_head_id),
        .o_head_votes  (ch_head_votes)
    );

    // top-k count: all entries for zero or an oversize limit, capped at the result limit
    always_comb begin
        lim_ext = CMPW'(r_lim);
        cnt_ext = CMPW'(r_count);
        pick    = ((lim_ext == '0) || (lim_ext > cnt_ext)) ? cnt_ext : lim_ext;
        if (pick > CMPW'(RESULT_LIMIT)) begin
            pick = CMPW'(RESULT_LIMIT);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    n_state = ((r_cmd == CMD_TOPK) && (r_count != '0)) ? S_LIST : S_IDLE;
                end
            end
            S_LIST: begin
                if (list_step && (r_rot == CW'(CAPACITY - 1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell commands, result loads and counters
    always_comb begin
        cell_op   = CELL_HOLD;
        wrap      = 1'b0;
        load      = 1'b0;
        ld_status = STAT_MISSING;
        ld_id     = '0;
        ld_votes  = '0;
        ld_last   = 1'b1;
        n_count   = r_count;
        n_rot     = r_rot;
        unique case (r_state)
            S_IDLE, S_LOOK: begin
            end
            S_APPLY: begin
                if (out_free) begin
                    load = 1'b1;
                    n_rot = '0;
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            if (r_found) begin
                                ld_status = STAT_BUMPED;
                                ld_id     = r_id;
                                ld_votes  = r_new_votes;
                                cell_op   = CELL_PLACE;
                            end else if (r_count == CW'(CAPACITY)) begin
                                ld_status = STAT_FULL;
                            end else begin
                                ld_status = STAT_OK;
                                ld_id     = r_id;
                                ld_votes  = r_new_votes;
                                cell_op   = CELL_PLACE;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        CMD_ADD: begin
                            if (r_found) begin
                                ld_status = STAT_OK;
                                ld_id     = r_id;
                                ld_votes  = r_new_votes;
                                cell_op   = CELL_PLACE;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (r_count != '0) begin
                                ld_status = STAT_OK;
                                ld_id     = ch_head_id;
                                ld_votes  = ch_head_votes;
                                cell_op   = CELL_SHIFT;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        CMD_GET: begin
                            if (r_found) begin
                                ld_status = STAT_OK;
                                ld_id     = r_id;
                                ld_votes  = r_old_votes;
                            end
                        end
                        CMD_TOPK: begin
                            if (r_count != '0) begin
                                load = 1'b0;
                            end
                        end
                        CMD_CLEAR: begin
                            ld_status = STAT_OK;
                            cell_op   = CELL_CLEAR;
                            n_count   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (list_step) begin
                    cell_op = CELL_SHIFT;
                    wrap    = 1'b1;
                    n_rot   = rot_inc;
                    if (emitting) begin
                        load      = 1'b1;
                        ld_status = STAT_OK;
                        ld_id     = ch_head_id;
                        ld_votes  = ch_head_votes;
                        ld_last   = (rot_inc == r_total);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, lookup results and result payload
    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
        if (accept) begin
            r_cmd <= t_cmd'(i_s_tdata[CMD_W-1:0]);
            r_id  <= i_s_tdata[CMD_W +: ID_WIDTH];
            r_iv  <= i_s_tdata[CMD_W + ID_WIDTH +: VOTE_WIDTH];
            r_lim <= i_s_tdata[CMD_W + ID_WIDTH + VOTE_WIDTH +: LIMIT_W];
        end
        if (r_state == S_LOOK) begin
            r_found     <= ch_found;
            r_hole      <= ch_found ? CW'(ch_pos) : r_count;
            r_old_votes <= ch_match_votes;
            if (ch_found) begin
                r_new_votes <= (ch_match_votes == VOTE_MAX) ? ch_match_votes
                                                            : ch_match_votes + VOTE_WIDTH'(1);
            end else begin
                r_new_votes <= r_iv;
            end
            r_total <= CW'(pick);
        end
        if (load) begin
            r_out_status <= ld_status;
            r_out_id     <= ld_id;
            r_out_votes  <= ld_votes;
            r_out_last   <= ld_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PADW{1'b0}}, r_out_votes, r_out_id};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

@@ verif/vote_priority_queue_unit_test.sv @@
`timescale 1ns / 1ps

module vote_priority_queue_unit_test;
    import vpq_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam int ID_W     = ID_WIDTH_DEF;
    localparam int VOTE_W   = VOTE_WIDTH_DEF;
    localparam int IN_W     = ((CMD_W + ID_W + VOTE_W + LIMIT_W + 7) / 8) * 8;
    localparam int OUT_W    = ((ID_W + VOTE_W + 7) / 8) * 8;
    localparam int FILL_W   = IN_W - (CMD_W + ID_W + VOTE_W + LIMIT_W);

    // command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic [VOTE_W-1:0] VOTE_MAX = {VOTE_W{1'b1}};

    // random command mixes
    localparam int MIX_FILL     = 0;
    localparam int MIX_BALANCED = 1;
    localparam int MIX_DRAIN    = 2;

    localparam int ID_POOL_SIZE   = 48;
    localparam int RANDOM_ITEMS   = 410;
    localparam int PHASE_ITEMS    = 82;
    localparam int MIX_BLOCK      = 45;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [CMD_W-1:0]   command;
        logic [ID_W-1:0]    item_id;
        logic [VOTE_W-1:0]  initial_votes;
        logic [LIMIT_W-1:0] top_limit;
    } t_vote_request;

    typedef struct {
        t_status           status;
        logic [ID_W-1:0]   result_id;
        logic [VOTE_W-1:0] result_votes;
        logic              last;
    } t_vote_result;

    typedef struct {
        t_vote_request rq;
        bit            typed;
        t_vote_result  want;
    } t_directed_row;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [OUT_W-1:0]    m_tdata;    // result_id, result_votes
    logic [STATUS_W-1:0] m_tuser;    // status
    logic                m_tlast;

    // sorted chain, highest votes first, lower id first on ties
    logic [ID_W-1:0]     chain_id[CAPACITY];
    logic [VOTE_W-1:0]   chain_votes[CAPACITY];
    int                  chain_count = 0;

    t_vote_result        step_results[$];
    t_vote_result        awaited_results[$];
    logic [ID_W-1:0]     id_pool[ID_POOL_SIZE];

    int                  fail_count     = 0;
    int                  checked_count  = 0;
    int                  quiet_cycles   = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_left      = 0;
    bit                  hold_request   = 1'b0;

    // extremes, every command, the missing status, saturation and tie order
    t_directed_row directed_rows[19] = '{
        '{'{CMD_EXTRACT, 16'h0000, 16'h0000, 6'd0},  1'b1, '{STAT_MISSING, 16'h0000, 16'h0000, 1'b1}},
        '{'{CMD_TOPK,    16'h0000, 16'h0000, 6'd0},  1'b1, '{STAT_MISSING, 16'h0000, 16'h0000, 1'b1}},
        '{'{CMD_GET,     16'h0000, 16'h0000, 6'd0},  1'b1, '{STAT_MISSING, 16'h0000, 16'h0000, 1'b1}},
        '{'{CMD_ADD,     16'hFFFF, 16'hFFFF, 6'd63}, 1'b1, '{STAT_MISSING, 16'h0000, 16'h0000, 1'b1}},
        '{'{CMD_SPARE_6, 16'h1234, 16'h5678, 6'd5},  1'b1, '{STAT_MISSING, 16'h0000, 16'h0000, 1'b1}},
        '{'{CMD_SPARE_7, 16'hFFFF, 16'hFFFF, 6'd63}, 1'b1, '{STAT_MISSING, 16'h0000, 16'h0000, 1'b1}},
        '{'{CMD_INSERT,  16'hFFFF, 16'hFFFF, 6'd0},  1'b1, '{STAT_OK,      16'hFFFF, 16'hFFFF, 1'b1}},
        '{'{CMD_INSERT,  16'h0000, 16'hFFFF, 6'd0},  1'b1, '{STAT_OK,      16'h0000, 16'hFFFF, 1'b1}},
        '{'{CMD_INSERT,  16'h0000, 16'h0000, 6'd0},  1'b1, '{STAT_BUMPED,  16'h0000, 16'hFFFF, 1'b1}},
        '{'{CMD_ADD,     16'hFFFF, 16'h0000, 6'd0},  1'b1, '{STAT_OK,      16'hFFFF, 16'hFFFF, 1'b1}},
        '{'{CMD_INSERT,  16'h1234, 16'h0000, 6'd0},  1'b1, '{STAT_OK,      16'h1234, 16'h0000, 1'b1}},
        '{'{CMD_GET,     16'h1234, 16'h0000, 6'd0},  1'b1, '{STAT_OK,      16'h1234, 16'h0000, 1'b1}},
        '{'{CMD_ADD,     16'h1234, 16'h0000, 6'd0},  1'b1, '{STAT_OK,      16'h1234, 16'h0001, 1'b1}},
        '{'{CMD_TOPK,    16'h0000, 16'h0000, 6'd0},  1'b0, '{STAT_OK,      16'h0000, 16'h0000, 1'b0}},
        '{'{CMD_TOPK,    16'h0000, 16'h0000, 6'd1},  1'b0, '{STAT_OK,      16'h0000, 16'h0000, 1'b0}},
        '{'{CMD_TOPK,    16'hFFFF, 16'hFFFF, 6'd63}, 1'b0, '{STAT_OK,      16'h0000, 16'h0000, 1'b0}},
        '{'{CMD_EXTRACT, 16'h0000, 16'h0000, 6'd0},  1'b1, '{STAT_OK,      16'h0000, 16'hFFFF, 1'b1}},
        '{'{CMD_CLEAR,   16'hFFFF, 16'hFFFF, 6'd63}, 1'b1, '{STAT_OK,      16'h0000, 16'h0000, 1'b1}},
        '{'{CMD_EXTRACT, 16'h0000, 16'h0000, 6'd0},  1'b1, '{STAT_MISSING, 16'h0000, 16'h0000, 1'b1}}
    };

    vote_priority_queue_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // queue predictor
    // ---------------------------------------------------------------

    function automatic bit ranks_ahead(logic [VOTE_W-1:0] va, logic [ID_W-1:0] ia,
                                       logic [VOTE_W-1:0] vb, logic [ID_W-1:0] ib);
        return (va > vb) || (va == vb && ia < ib);
    endfunction

    function automatic int find_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < chain_count; i++)
            if (chain_id[i] == id)
                return i;
        return -1;
    endfunction

    // move an entry forward until the chain is sorted again
    function automatic int move_forward(int p);
        logic [ID_W-1:0]   tid;
        logic [VOTE_W-1:0] tvotes;
        while (p > 0 && ranks_ahead(chain_votes[p], chain_id[p],
                                    chain_votes[p-1], chain_id[p-1])) begin
            tid            = chain_id[p];
            tvotes         = chain_votes[p];
            chain_id[p]    = chain_id[p-1];
            chain_votes[p] = chain_votes[p-1];
            chain_id[p-1]    = tid;
            chain_votes[p-1] = tvotes;
            p--;
        end
        return p;
    endfunction

    // one vote more, saturating
    function automatic int add_one_vote(int p);
        if (chain_votes[p] != VOTE_MAX)
            chain_votes[p] = chain_votes[p] + 1'b1;
        return move_forward(p);
    endfunction

    function automatic void note_result(t_status st, logic [ID_W-1:0] id,
                                        logic [VOTE_W-1:0] votes, logic last);
        t_vote_result r;
        r.status       = st;
        r.result_id    = id;
        r.result_votes = votes;
        r.last         = last;
        step_results.insert(step_results.size(), r);
    endfunction

    // update the chain for one command and list the results it causes
    function automatic void apply_vote_command(t_vote_request rq);
        int p;
        int n;
        step_results.delete();
        p = find_slot(rq.item_id);
        case (rq.command)
            CMD_INSERT: begin
                if (p >= 0) begin
                    p = add_one_vote(p);
                    note_result(STAT_BUMPED, chain_id[p], chain_votes[p], 1'b1);
                end else if (chain_count >= CAPACITY) begin
                    note_result(STAT_FULL, '0, '0, 1'b1);
                end else begin
                    chain_id[chain_count]    = rq.item_id;
                    chain_votes[chain_count] = rq.initial_votes;
                    chain_count++;
                    p = move_forward(chain_count - 1);
                    note_result(STAT_OK, chain_id[p], chain_votes[p], 1'b1);
                end
            end
            CMD_ADD: begin
                if (p < 0) begin
                    note_result(STAT_MISSING, '0, '0, 1'b1);
                end else begin
                    p = add_one_vote(p);
                    note_result(STAT_OK, chain_id[p], chain_votes[p], 1'b1);
                end
            end
            CMD_EXTRACT: begin
                if (chain_count == 0) begin
                    note_result(STAT_MISSING, '0, '0, 1'b1);
                end else begin
                    note_result(STAT_OK, chain_id[0], chain_votes[0], 1'b1);
                    for (int i = 1; i < chain_count; i++) begin
                        chain_id[i-1]    = chain_id[i];
                        chain_votes[i-1] = chain_votes[i];
                    end
                    chain_count--;
                end
            end
            CMD_GET: begin
                if (p < 0)
                    note_result(STAT_MISSING, '0, '0, 1'b1);
                else
                    note_result(STAT_OK, chain_id[p], chain_votes[p], 1'b1);
            end
            CMD_TOPK: begin
                if (chain_count == 0) begin
                    note_result(STAT_MISSING, '0, '0, 1'b1);
                end else begin
                    n = (rq.top_limit == 0 || rq.top_limit > chain_count) ?
                        chain_count : int'(rq.top_limit);
                    if (n > RESULT_LIMIT)
                        n = RESULT_LIMIT;
                    for (int i = 0; i < n; i++)
                        note_result(STAT_OK, chain_id[i], chain_votes[i], i == n - 1);
                end
            end
            CMD_CLEAR: begin
                chain_count = 0;
                note_result(STAT_OK, '0, '0, 1'b1);
            end
            default: begin
                note_result(STAT_MISSING, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic t_vote_request random_request(int mix);
        t_vote_request rq;
        int roll;
        logic [CMD_W-1:0] spare;
        spare = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
        roll  = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                rq.command = (roll < 85) ? CMD_INSERT :
                             (roll < 90) ? CMD_ADD :
                             (roll < 95) ? CMD_GET :
                             (roll < 98) ? CMD_TOPK : spare;
            MIX_BALANCED:
                rq.command = (roll < 30) ? CMD_INSERT :
                             (roll < 50) ? CMD_ADD :
                             (roll < 65) ? CMD_EXTRACT :
                             (roll < 82) ? CMD_GET :
                             (roll < 94) ? CMD_TOPK :
                             (roll < 97) ? CMD_CLEAR : spare;
            MIX_DRAIN:
                rq.command = (roll < 45) ? CMD_EXTRACT :
                             (roll < 63) ? CMD_GET :
                             (roll < 83) ? CMD_TOPK :
                             (roll < 93) ? CMD_ADD :
                             (roll < 98) ? CMD_INSERT : spare;
            default:
                rq.command = spare;
        endcase

        // mostly a small id set so that lookups hit
        if ($urandom_range(0, 99) < 75)
            rq.item_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        else
            rq.item_id = ID_W'($urandom_range(0, 65535));

        // small counts force ties, near-max counts reach saturation
        roll = $urandom_range(0, 99);
        if (roll < 35)
            rq.initial_votes = VOTE_W'($urandom_range(0, 3));
        else if (roll < 45)
            rq.initial_votes = VOTE_MAX - VOTE_W'($urandom_range(0, 1));
        else
            rq.initial_votes = VOTE_W'($urandom_range(0, 65535));

        roll = $urandom_range(0, 99);
        if (roll < 25)
            rq.top_limit = '0;
        else if (roll < 75)
            rq.top_limit = LIMIT_W'($urandom_range(1, 6));
        else
            rq.top_limit = LIMIT_W'($urandom_range(0, 63));
        return rq;
    endfunction

    // offer one item, predict on accept
    task automatic offer_item(t_vote_request rq, bit typed, t_vote_result want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{FILL_W{1'b0}}, rq.top_limit, rq.initial_votes, rq.item_id, rq.command};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_vote_command(rq);
        if (typed)
            awaited_results.insert(awaited_results.size(), want);
        else
            foreach (step_results[i])
                awaited_results.insert(awaited_results.size(), step_results[i]);
    endtask

    initial begin
        int phase;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom_range(0, 65535));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

        // idling phases: none, sender, receiver, both, then receiver hold-off
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % PHASE_ITEMS == 0) begin
                phase = k / PHASE_ITEMS;
                send_idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 16 : 0;
                recv_stall_pct = (phase == 2) ? 64 : (phase == 3) ? 16 : 0;
                if (phase == PRESSURE_PHASE)
                    hold_request = 1'b1;
            end
            offer_item(random_request((k / MIX_BLOCK) % 3), 1'b0, '{STAT_OK, '0, '0, 1'b0});
        end
        s_tvalid <= 1'b0;

        // drain
        recv_stall_pct = 0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (fail_count == 0)
            $display("vote_priority_queue_unit_test OK");
        else
            $display("vote_priority_queue_unit_test NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------
    // result checking and receiver backpressure
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("result %0d: %s got %h want %h", checked_count, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk) begin
        t_vote_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected item", m_tdata, '0);
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[ID_W-1:0] !== want.result_id)
                    report_mismatch("result_id", m_tdata[ID_W-1:0], want.result_id);
                if (m_tdata[ID_W +: VOTE_W] !== want.result_votes)
                    report_mismatch("result_votes", m_tdata[ID_W +: VOTE_W],
                                    want.result_votes);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
            checked_count++;
        end
    end

    // receiver ready, with a long hold-off so the block fills up and stalls its input
    always @(posedge clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("vote_priority_queue_unit_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ filelist.f @@
hw/rtl/vpq_pkg.sv
hw/rtl/vpq_cell.sv
hw/rtl/vpq_chain.sv
hw/rtl/vote_priority_queue_unit.sv
verif/vote_priority_queue_unit_test.sv
